// ===== design/qme_pkg.sv =====
// Shared types and constants of the quadratic motion extrapolator.
// Used by every design file; depends on nothing.
`timescale 1ns / 1ps

package qme_pkg;

	localparam int QME_HIST_DEPTH = 8;
	localparam int QME_FILL_W     = $clog2(QME_HIST_DEPTH + 1);
	localparam int QME_POS_W      = 32;
	localparam int QME_LA_W       = 8;
	localparam int QME_D1_W       = QME_POS_W + 1;
	localparam int QME_D2_W       = QME_POS_W + 2;
	localparam int QME_OPA_W      = 43;
	localparam int QME_PROD_W     = QME_OPA_W + QME_LA_W + 1;
	localparam int QME_SUM_W      = QME_PROD_W + 1;
	localparam int QME_IDX_W      = 2;

	localparam logic [1:0] QME_LAST_AXIS = 2'd2;

	typedef logic signed [QME_POS_W-1:0] pos_t;

	typedef enum logic [QME_IDX_W-1:0] {
		CFG_STD_LA  = 2'd0,
		CFG_START_X = 2'd1,
		CFG_START_Y = 2'd2,
		CFG_START_Z = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_EVAL,
		ST_DRAIN,
		ST_DONE
	} qme_state_t;

	typedef enum logic [1:0] {
		PH_MUL_D2,
		PH_ADD_D1,
		PH_MUL_W
	} qme_phase_t;

	typedef struct packed {
		logic       accept;
		logic       diff;
		logic       mul_d2;
		logic       add_d1;
		logic       mul_w;
		logic [1:0] axis;
		logic       use_query;
		logic       load_out;
	} qme_ctl_t;

endpackage

// ===== design/qme_if.sv =====
// Handshake channels of the extrapolator: sample items in, result items out.
// Depends on qme_pkg.
`timescale 1ns / 1ps

interface qme_sample_if;
	logic                           valid;
	logic                           ready;
	logic                           restart;
	qme_pkg::pos_t                  sample_x;
	qme_pkg::pos_t                  sample_y;
	qme_pkg::pos_t                  sample_z;
	logic [qme_pkg::QME_LA_W-1:0]   query_lookahead;

	modport source(output valid, restart, sample_x, sample_y, sample_z, query_lookahead,
		input ready);
	modport sink(input valid, restart, sample_x, sample_y, sample_z, query_lookahead,
		output ready);
endinterface

interface qme_result_if;
	logic          valid;
	logic          ready;
	qme_pkg::pos_t std_x;
	qme_pkg::pos_t std_y;
	qme_pkg::pos_t std_z;
	qme_pkg::pos_t ahead_x;
	qme_pkg::pos_t ahead_y;
	qme_pkg::pos_t ahead_z;
	logic          history_full;
	logic          saturated;

	modport source(output valid, std_x, std_y, std_z, ahead_x, ahead_y, ahead_z,
		history_full, saturated, input ready);
	modport sink(input valid, std_x, std_y, std_z, ahead_x, ahead_y, ahead_z,
		history_full, saturated, output ready);
endinterface

// ===== design/qme_history.sv =====
// Position history (three newest samples per axis), fill count and the
// first and second differences per axis. Depends on qme_pkg.
`timescale 1ns / 1ps

module qme_history (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic                               restart,
	input  qme_pkg::pos_t                      smp [3],
	input  logic                               diff,
	output qme_pkg::pos_t                      h0 [3],
	output logic signed [qme_pkg::QME_D1_W-1:0] d1 [3],
	output logic signed [qme_pkg::QME_D2_W-1:0] d2 [3],
	output logic                               full
);

	qme_pkg::pos_t                              hist_q [3][3];
	logic signed [qme_pkg::QME_D1_W-1:0]        d1_q [3];
	logic signed [qme_pkg::QME_D2_W-1:0]        d2_q [3];
	logic signed [qme_pkg::QME_D1_W-1:0]        d1_d [3];
	logic signed [qme_pkg::QME_D2_W-1:0]        d2_d [3];
	logic [qme_pkg::QME_FILL_W-1:0]             fill_q;
	logic [qme_pkg::QME_FILL_W-1:0]             fill_base;
	logic [qme_pkg::QME_FILL_W-1:0]             fill_nx;
	logic                                       full_q;

	localparam logic [qme_pkg::QME_FILL_W-1:0] DEPTH =
		qme_pkg::QME_FILL_W'(qme_pkg::QME_HIST_DEPTH);

	// restart clears the count before this sample counts; stop at the depth
	always_comb begin
		fill_base = restart ? '0 : fill_q;
		fill_nx   = (fill_base < DEPTH) ? fill_base + 1'b1 : fill_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			full_q <= 1'b0;
		end else if (accept) begin
			fill_q <= fill_nx;
			full_q <= (fill_nx >= DEPTH);
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			d1_d[a] = $signed({hist_q[a][0][31], hist_q[a][0]})
				- $signed({hist_q[a][1][31], hist_q[a][1]});
			d2_d[a] = $signed({{2{hist_q[a][0][31]}}, hist_q[a][0]})
				- $signed({hist_q[a][1][31], hist_q[a][1], 1'b0})
				+ $signed({{2{hist_q[a][2][31]}}, hist_q[a][2]});
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (accept) begin
				hist_q[a][2] <= hist_q[a][1];
				hist_q[a][1] <= hist_q[a][0];
				hist_q[a][0] <= smp[a];
			end
			if (diff) begin
				d1_q[a] <= d1_d[a];
				d2_q[a] <= d2_d[a];
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			h0[a] = hist_q[a][0];
			d1[a] = d1_q[a];
			d2[a] = d2_q[a];
		end
	end

	assign full = full_q;

endmodule

// ===== design/qme_mul.sv =====
// Shared multiplier: signed operand times unsigned lookahead, product registered.
// Depends on qme_pkg.
`timescale 1ns / 1ps

module qme_mul (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [qme_pkg::QME_OPA_W-1:0]  a,
	input  logic [qme_pkg::QME_LA_W-1:0]          b,
	output logic signed [qme_pkg::QME_PROD_W-1:0] p_q
);

	logic signed [qme_pkg::QME_LA_W:0]     b_s;
	logic signed [qme_pkg::QME_PROD_W-1:0] a_x;
	logic signed [qme_pkg::QME_PROD_W-1:0] b_x;

	always_comb begin
		b_s = $signed({1'b0, b});
		a_x = qme_pkg::QME_PROD_W'(a);
		b_x = qme_pkg::QME_PROD_W'(b_s);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a_x * b_x;
		end
	end

endmodule

// ===== design/qme_ctrl.sv =====
// Sequencer: walks six evaluations (std then query, axes x y z), three phases
// each, through the shared multiplier. Depends on qme_pkg.
`timescale 1ns / 1ps

module qme_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_free,
	input  logic              full,
	output logic              in_ready,
	output qme_pkg::qme_ctl_t ctl
);

	qme_pkg::qme_state_t state_q, state_d;
	qme_pkg::qme_phase_t ph_q;
	logic [1:0]          ax_q;
	logic                lk_q;
	logic                last_eval;

	assign last_eval = (ph_q == qme_pkg::PH_MUL_W) && (ax_q == qme_pkg::QME_LAST_AXIS) && lk_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qme_pkg::ST_IDLE: begin
				if (in_valid) state_d = qme_pkg::ST_DIFF;
			end
			qme_pkg::ST_DIFF: begin
				state_d = full ? qme_pkg::ST_EVAL : qme_pkg::ST_DONE;
			end
			qme_pkg::ST_EVAL: begin
				if (last_eval) state_d = qme_pkg::ST_DRAIN;
			end
			qme_pkg::ST_DRAIN: begin
				state_d = qme_pkg::ST_DONE;
			end
			qme_pkg::ST_DONE: begin
				if (out_free) state_d = qme_pkg::ST_IDLE;
			end
			default: begin
				state_d = qme_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = (state_q == qme_pkg::ST_IDLE);
		ctl.accept    = (state_q == qme_pkg::ST_IDLE) && in_valid;
		ctl.diff      = (state_q == qme_pkg::ST_DIFF);
		ctl.mul_d2    = (state_q == qme_pkg::ST_EVAL) && (ph_q == qme_pkg::PH_MUL_D2);
		ctl.add_d1    = (state_q == qme_pkg::ST_EVAL) && (ph_q == qme_pkg::PH_ADD_D1);
		ctl.mul_w     = (state_q == qme_pkg::ST_EVAL) && (ph_q == qme_pkg::PH_MUL_W);
		ctl.axis      = ax_q;
		ctl.use_query = lk_q;
		ctl.load_out  = (state_q == qme_pkg::ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qme_pkg::ST_IDLE;
			ph_q    <= qme_pkg::PH_MUL_D2;
			ax_q    <= '0;
			lk_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == qme_pkg::ST_DIFF) begin
				ph_q <= qme_pkg::PH_MUL_D2;
				ax_q <= '0;
				lk_q <= 1'b0;
			end else if (state_q == qme_pkg::ST_EVAL) begin
				unique case (ph_q)
					qme_pkg::PH_MUL_D2: ph_q <= qme_pkg::PH_ADD_D1;
					qme_pkg::PH_ADD_D1: ph_q <= qme_pkg::PH_MUL_W;
					qme_pkg::PH_MUL_W: begin
						ph_q <= qme_pkg::PH_MUL_D2;
						// advance axis; after z switch to the query lookahead
						if (ax_q == qme_pkg::QME_LAST_AXIS) begin
							ax_q <= '0;
							lk_q <= 1'b1;
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end
					default: ph_q <= qme_pkg::PH_MUL_D2;
				endcase
			end
		end
	end

endmodule

// ===== design/quadratic_motion_extrapolator.sv =====
// Quadratic motion extrapolator, top level: config registers, held prediction,
// finishing adder with saturation and the result register. Depends on qme_pkg,
// qme_if, qme_history, qme_mul and qme_ctrl.
`timescale 1ns / 1ps

// One item is one position sample. While the history holds fewer than
// QME_HIST_DEPTH samples since the last restart, an item goes from the
// difference state straight to the done state. Once the history is full,
// each axis is evaluated for the standard and for the query lookahead as
// P0 + floor(t*(2*d1 + d2*t)/2), and the six evaluations run one after the
// other through a single registered multiplier, each as d2 times t, the sum
// with 2*d1, and that sum times t. A finished result sits in an output
// register, so the next item is taken while it waits; the block stalls only
// when a second result is ready before the first was taken. Configuration
// writes are taken at any time but are meant for an idle block; writing a
// start register loads the held prediction of that axis.

module quadratic_motion_extrapolator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [qme_pkg::QME_IDX_W-1:0]   cfg_index,
	input  logic [qme_pkg::QME_POS_W-1:0]   cfg_data,
	qme_sample_if.sink                      sample_ch,
	qme_result_if.source                    result_ch
);

	qme_pkg::qme_ctl_t                          ctl;
	qme_pkg::pos_t                              smp [3];
	qme_pkg::pos_t                              h0 [3];
	logic signed [qme_pkg::QME_D1_W-1:0]        d1 [3];
	logic signed [qme_pkg::QME_D2_W-1:0]        d2 [3];
	logic                                       full;
	logic                                       out_free;

	logic [qme_pkg::QME_LA_W-1:0]               std_la_q;
	logic [qme_pkg::QME_LA_W-1:0]               tq_q;
	qme_pkg::pos_t                              held_q [3];
	qme_pkg::pos_t                              ahead_q [3];
	logic                                       sat_q;

	logic signed [qme_pkg::QME_OPA_W-1:0]       w_q;
	logic signed [qme_pkg::QME_OPA_W-1:0]       w_d;
	logic signed [qme_pkg::QME_OPA_W-1:0]       mul_a;
	logic [qme_pkg::QME_LA_W-1:0]               mul_b;
	logic signed [qme_pkg::QME_PROD_W-1:0]      m_q;

	logic                                       fin_v_q;
	logic [1:0]                                 fin_ax_q;
	logic                                       fin_lk_q;
	logic signed [qme_pkg::QME_SUM_W-1:0]       sum;
	logic                                       sat_hi;
	logic                                       sat_lo;
	qme_pkg::pos_t                              fin_r;

	logic                                       out_valid_q;

	assign smp[0] = sample_ch.sample_x;
	assign smp[1] = sample_ch.sample_y;
	assign smp[2] = sample_ch.sample_z;

	qme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.out_free (out_free),
		.full     (full),
		.in_ready (sample_ch.ready),
		.ctl      (ctl)
	);

	qme_history u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (ctl.accept),
		.restart (sample_ch.restart),
		.smp     (smp),
		.diff    (ctl.diff),
		.h0      (h0),
		.d1      (d1),
		.d2      (d2),
		.full    (full)
	);

	always_comb begin
		mul_a = ctl.mul_d2 ? qme_pkg::QME_OPA_W'(d2[ctl.axis]) : w_q;
		mul_b = ctl.use_query ? tq_q : std_la_q;
		// w = 2*d1 + d2*t, with d2*t in the low bits of the product
		w_d   = $signed({{(qme_pkg::QME_OPA_W - qme_pkg::QME_D1_W - 1){d1[ctl.axis][32]}},
			d1[ctl.axis], 1'b0}) + $signed(m_q[qme_pkg::QME_OPA_W-1:0]);
	end

	qme_mul u_mul (
		.clk (clk),
		.en  (ctl.mul_d2 | ctl.mul_w),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (m_q)
	);

	always_ff @(posedge clk) begin
		if (ctl.add_d1) begin
			w_q <= w_d;
		end
		if (ctl.accept) begin
			tq_q <= sample_ch.query_lookahead;
		end
		if (ctl.mul_w) begin
			fin_ax_q <= ctl.axis;
			fin_lk_q <= ctl.use_query;
		end
	end

	// finish: P0 + product/2 (floor), clamp to the signed 32-bit range
	always_comb begin
		sum    = $signed({{(qme_pkg::QME_SUM_W - qme_pkg::QME_POS_W){h0[fin_ax_q][31]}},
			h0[fin_ax_q]}) + $signed({{2{m_q[qme_pkg::QME_PROD_W-1]}},
			m_q[qme_pkg::QME_PROD_W-1:1]});
		sat_hi = !sum[qme_pkg::QME_SUM_W-1] && (|sum[qme_pkg::QME_SUM_W-2:31]);
		sat_lo = sum[qme_pkg::QME_SUM_W-1] && !(&sum[qme_pkg::QME_SUM_W-2:31]);
		priority if (sat_hi) begin
			fin_r = {1'b0, {(qme_pkg::QME_POS_W-1){1'b1}}};
		end else if (sat_lo) begin
			fin_r = {1'b1, {(qme_pkg::QME_POS_W-1){1'b0}}};
		end else begin
			fin_r = sum[qme_pkg::QME_POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_q <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			fin_v_q <= ctl.mul_w;
			if (ctl.accept) begin
				sat_q <= 1'b0;
			end else if (fin_v_q) begin
				sat_q <= sat_q | sat_hi | sat_lo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_v_q && fin_lk_q) begin
			ahead_q[fin_ax_q] <= fin_r;
		end
	end

	// start-register writes and standard results both land in the held prediction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_la_q <= qme_pkg::QME_LA_W'(1);
			for (int a = 0; a < 3; a++) begin
				held_q[a] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				unique case (qme_pkg::cfg_reg_t'(cfg_index))
					qme_pkg::CFG_STD_LA:  std_la_q  <= cfg_data[qme_pkg::QME_LA_W-1:0];
					qme_pkg::CFG_START_X: held_q[0] <= cfg_data;
					qme_pkg::CFG_START_Y: held_q[1] <= cfg_data;
					qme_pkg::CFG_START_Z: held_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (fin_v_q && !fin_lk_q) begin
				held_q[fin_ax_q] <= fin_r;
			end
		end
	end

	assign out_free = !out_valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			result_ch.std_x        <= held_q[0];
			result_ch.std_y        <= held_q[1];
			result_ch.std_z        <= held_q[2];
			result_ch.ahead_x      <= full ? ahead_q[0] : held_q[0];
			result_ch.ahead_y      <= full ? ahead_q[1] : held_q[1];
			result_ch.ahead_z      <= full ? ahead_q[2] : held_q[2];
			result_ch.history_full <= full;
			result_ch.saturated    <= sat_q;
		end
	end

	assign result_ch.valid = out_valid_q;

endmodule

// ===== design/qme_checker.sv =====
// Port-level checks of the extrapolator, attached to the top level by bind.
// Depends on qme_pkg and quadratic_motion_extrapolator.
`timescale 1ns / 1ps

module qme_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input qme_pkg::pos_t std_x,
	input qme_pkg::pos_t ahead_x,
	input qme_pkg::pos_t std_z,
	input qme_pkg::pos_t ahead_z,
	input logic          history_full,
	input logic          saturated
);

	// the block works on one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while previous item still in work");

	// short history: both predictions are the held one, nothing clamped
	a_short_history: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !history_full |-> std_x == ahead_x && std_z == ahead_z && !saturated)
		else $error("result without full history differs from held prediction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(std_x) && $stable(ahead_z) && $stable(saturated))
		else $error("stalled result changed");

endmodule

bind quadratic_motion_extrapolator qme_checker u_qme_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample_ch.valid),
	.in_ready     (sample_ch.ready),
	.out_valid    (result_ch.valid),
	.out_ready    (result_ch.ready),
	.std_x        (result_ch.std_x),
	.ahead_x      (result_ch.ahead_x),
	.std_z        (result_ch.std_z),
	.ahead_z      (result_ch.ahead_z),
	.history_full (result_ch.history_full),
	.saturated    (result_ch.saturated)
);
